// ===== rtl/core/tfd_pkg.sv =====
`default_nettype none

package tfd_pkg;

  // frame constants
  localparam logic [7:0]  SyncA       = 8'h4D;
  localparam logic [7:0]  SyncB       = 8'h54;
  localparam logic [7:0]  CrcPoly     = 8'h07;
  localparam logic [15:0] MinBody     = 16'd7;
  localparam logic [7:0]  GoodVersion = 8'h01;

  // widths of the per-run status counters
  localparam int unsigned CntW = 6;
  localparam int unsigned FaW  = 3;

  localparam logic FuncByte    = 1'b0;
  localparam logic FuncRestart = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_STATUS
  } tfd_state_e;

  // outcome of checking one byte during a scan
  typedef enum logic [2:0] {
    EV_NONE,
    EV_DROP_SYNC,
    EV_DROP_LEN,
    EV_DROP_VER,
    EV_DROP_CRC,
    EV_DONE,
    EV_ACCEPT
  } tfd_event_e;

  typedef struct packed {
    logic              is_status;
    logic [7:0]        frame_byte;
    logic              frame_end;
    logic              run_last;
    logic [CntW-1:0]   resync_bytes;
    logic [CntW-1:0]   length_errors;
    logic [CntW-1:0]   version_errors;
    logic [CntW-1:0]   crc_errors;
    logic [FaW-1:0]    frames_accepted;
    logic [31:0]       gap_total;
    logic [15:0]       last_sequence;
  } tfd_item_t;

  // crc-8, msb first, one byte folded in
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CrcPoly;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tfd_if.sv =====
`default_nettype none

interface tfd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface tfd_out_if;
  logic        valid;
  logic        ready;
  logic        is_status;
  logic [7:0]  frame_byte;
  logic        frame_end;
  logic        run_last;
  logic [5:0]  resync_bytes;
  logic [5:0]  length_errors;
  logic [5:0]  version_errors;
  logic [5:0]  crc_errors;
  logic [2:0]  frames_accepted;
  logic [31:0] gap_total;
  logic [15:0] last_sequence;

  modport source (output valid, output is_status, output frame_byte, output frame_end,
                  output run_last, output resync_bytes, output length_errors,
                  output version_errors, output crc_errors, output frames_accepted,
                  output gap_total, output last_sequence, input ready);
  modport sink   (input valid, input is_status, input frame_byte, input frame_end,
                  input run_last, input resync_bytes, input length_errors,
                  input version_errors, input crc_errors, input frames_accepted,
                  input gap_total, input last_sequence, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/telemetry_frame_deframer.sv =====
`default_nettype none

// channel   dir  payload                                       beat taken when
// in_i      in   func, rx_byte                                 valid & ready
// out_o     out  frame byte or end-of-run status (11 fields)   valid & ready
//
// one input beat at a time; in_i.ready is high only while the sequencer is idle
// per parse attempt: a start state, then one window byte read per cycle in the scan
// (the read port streams one byte a cycle into a registered read data); an accepted
// frame is emitted byte by byte, each byte through a read state and an output state,
// the output state waiting while the output is stalled
// a pending output beat does not block the next input beat once the status is loaded
// asynchronous active-low reset clears control state; window memory is not cleared

module telemetry_frame_deframer #(
  parameter int unsigned MAX_FRAME_BYTES = 48
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  tfd_in_if.sink    in_i,
  tfd_out_if.source out_o
);
  import tfd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FRAME_BYTES);     // window address
  localparam int unsigned FW = $clog2(MAX_FRAME_BYTES + 1); // fill / index
  localparam logic [15:0] MaxBody = 16'(MAX_FRAME_BYTES - 4);

  // window memory, used as a ring: head_q points at the front byte
  logic [7:0] win_mem [MAX_FRAME_BYTES];
  logic [7:0] rd_data_q;

  tfd_state_e state_q, state_d;

  logic [AW-1:0]   head_q, head_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic [FW-1:0]   rd_idx_q, rd_idx_d;    // next index to read
  logic [FW-1:0]   chk_idx_q, chk_idx_d;  // index of byte in rd_data_q
  logic            chk_vld_q, chk_vld_d;
  logic [7:0]      b0_q, b0_d;
  logic [7:0]      len_lo_q, len_lo_d;
  logic [7:0]      seq_lo_q, seq_lo_d;
  logic [15:0]     seq_q, seq_d;
  logic [FW-1:0]   flen_q, flen_d;
  logic [7:0]      crc_q, crc_d;
  logic            have_seq_q, have_seq_d;
  logic [15:0]     prev_seq_q, prev_seq_d;
  logic [31:0]     gap_q, gap_d;
  logic [CntW-1:0] rs_q, rs_d, le_q, le_d, ve_q, ve_d, ce_q, ce_d;
  logic [FaW-1:0]  fa_q, fa_d;
  tfd_item_t       out_q, out_d;
  logic            out_vld_q, out_vld_d;

  logic            in_acc;
  logic            out_free;
  logic            rd_en;
  logic [FW-1:0]   rd_idx;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            wr_en;
  tfd_event_e      ev;
  logic [15:0]     body;
  logic [15:0]     delta;
  logic [32:0]     gap_sum;
  logic            emit_last;

  // ring address: a below the window size, b at most the window size
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [FW-1:0] b);
    logic [AW+1:0] s;
    s = {2'b00, a} + (AW+2)'(b);
    if (s >= (AW+2)'(MAX_FRAME_BYTES)) s = s - (AW+2)'(MAX_FRAME_BYTES);
    return s[AW-1:0];
  endfunction

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign emit_last  = (rd_idx_q == flen_q - FW'(1));

  assign rd_idx  = rd_idx_q;
  assign rd_addr = ring_add(head_q, rd_idx);
  assign wr_addr = ring_add(head_q, fill_q);
  assign wr_en   = in_acc && (in_i.func == FuncByte) && (fill_q < FW'(MAX_FRAME_BYTES));
  assign rd_en   = ((state_q == S_SCAN) && (rd_idx_q < fill_q)) || (state_q == S_EMIT_RD);

  always_ff @(posedge clk_i) begin
    if (wr_en) win_mem[wr_addr] <= in_i.rx_byte;
    if (rd_en) rd_data_q <= win_mem[rd_addr];
  end

  // check of the byte that came back from the window
  assign body = {rd_data_q, len_lo_q};
  always_comb begin
    ev = EV_NONE;
    if (state_q == S_SCAN && chk_vld_q) begin
      if (chk_idx_q == FW'(1)) begin
        if (b0_q != SyncA || rd_data_q != SyncB) ev = EV_DROP_SYNC;
        else if (fill_q < FW'(4))                ev = EV_DONE;
      end else if (chk_idx_q == FW'(3)) begin
        if (body < MinBody || body > MaxBody)    ev = EV_DROP_LEN;
        else if ({{(16-FW){1'b0}}, fill_q} < body + 16'd4) ev = EV_DONE;
      end else if (chk_idx_q == FW'(4) && rd_data_q != GoodVersion) begin
        ev = EV_DROP_VER;
      end else if (chk_idx_q > FW'(4) && chk_idx_q == flen_q - FW'(1)) begin
        if (crc_q != rd_data_q) ev = EV_DROP_CRC;
        else                    ev = EV_ACCEPT;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = (in_i.func == FuncRestart) ? S_STATUS : S_START;
      end
      S_START: begin
        state_d = (fill_q < FW'(2)) ? S_STATUS : S_SCAN;
      end
      S_SCAN: begin
        unique case (ev)
          EV_NONE:   state_d = S_SCAN;
          EV_DONE:   state_d = S_STATUS;
          EV_ACCEPT: state_d = S_EMIT_RD;
          default:   state_d = S_START;
        endcase
      end
      S_EMIT_RD: state_d = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (out_free) state_d = emit_last ? S_START : S_EMIT_RD;
      end
      S_STATUS: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign delta   = seq_q - prev_seq_q;
  assign gap_sum = {1'b0, gap_q} + {17'b0, delta - 16'd1};

  // datapath
  always_comb begin
    head_d     = head_q;
    fill_d     = fill_q;
    rd_idx_d   = rd_idx_q;
    chk_idx_d  = chk_idx_q;
    chk_vld_d  = chk_vld_q;
    b0_d       = b0_q;
    len_lo_d   = len_lo_q;
    seq_lo_d   = seq_lo_q;
    seq_d      = seq_q;
    flen_d     = flen_q;
    crc_d      = crc_q;
    have_seq_d = have_seq_q;
    prev_seq_d = prev_seq_q;
    gap_d      = gap_q;
    rs_d       = rs_q;
    le_d       = le_q;
    ve_d       = ve_q;
    ce_d       = ce_q;
    fa_d       = fa_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rs_d = '0;
          le_d = '0;
          ve_d = '0;
          ce_d = '0;
          fa_d = '0;
          if (in_i.func == FuncRestart) begin
            fill_d     = '0;
            have_seq_d = 1'b0;
          end else if (wr_en) begin
            fill_d = fill_q + FW'(1);
          end
        end
      end
      S_START: begin
        rd_idx_d  = '0;
        chk_vld_d = 1'b0;
        crc_d     = '0;
      end
      S_SCAN: begin
        rd_idx_d  = rd_en ? rd_idx_q + FW'(1) : rd_idx_q;
        chk_idx_d = rd_idx_q;
        chk_vld_d = rd_en;
        if (chk_vld_q) begin
          if (chk_idx_q == FW'(0)) b0_d = rd_data_q;
          if (chk_idx_q == FW'(2)) len_lo_d = rd_data_q;
          if (chk_idx_q == FW'(3)) flen_d = FW'(body) + FW'(4);
          if (chk_idx_q == FW'(5)) seq_lo_d = rd_data_q;
          if (chk_idx_q == FW'(6)) seq_d = {rd_data_q, seq_lo_q};
          if (chk_idx_q < FW'(4) || chk_idx_q != flen_q - FW'(1))
            crc_d = crc8_byte(crc_q, rd_data_q);
        end
        unique case (ev)
          EV_NONE: ;
          EV_DONE: ;
          EV_DROP_SYNC: rs_d = rs_q + CntW'(1);
          EV_DROP_LEN: begin
            rs_d = rs_q + CntW'(1);
            le_d = le_q + CntW'(1);
          end
          EV_DROP_VER: begin
            rs_d = rs_q + CntW'(1);
            ve_d = ve_q + CntW'(1);
          end
          EV_DROP_CRC: begin
            rs_d = rs_q + CntW'(1);
            ce_d = ce_q + CntW'(1);
          end
          EV_ACCEPT: begin
            if (have_seq_q && delta > 16'd1)
              gap_d = gap_sum[32] ? 32'hFFFF_FFFF : gap_sum[31:0];
            have_seq_d = 1'b1;
            prev_seq_d = seq_q;
            fa_d       = fa_q + FaW'(1);
            rd_idx_d   = '0;
          end
          default: ;
        endcase
        if (ev == EV_DROP_SYNC || ev == EV_DROP_LEN || ev == EV_DROP_VER ||
            ev == EV_DROP_CRC) begin
          head_d = ring_add(head_q, FW'(1));
          fill_d = fill_q - FW'(1);
        end
      end
      S_EMIT_RD: ;
      S_EMIT_OUT: begin
        if (out_free) begin
          out_d                = '0;
          out_d.frame_byte     = rd_data_q;
          out_d.frame_end      = emit_last;
          out_vld_d            = 1'b1;
          rd_idx_d             = rd_idx_q + FW'(1);
          if (emit_last) begin
            head_d = ring_add(head_q, flen_q);
            fill_d = fill_q - flen_q;
          end
        end
      end
      S_STATUS: begin
        if (out_free) begin
          out_d.is_status       = 1'b1;
          out_d.frame_byte      = '0;
          out_d.frame_end       = 1'b0;
          out_d.run_last        = 1'b1;
          out_d.resync_bytes    = rs_q;
          out_d.length_errors   = le_q;
          out_d.version_errors  = ve_q;
          out_d.crc_errors      = ce_q;
          out_d.frames_accepted = fa_q;
          out_d.gap_total       = gap_q;
          out_d.last_sequence   = prev_seq_q;
          out_vld_d             = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      fill_q     <= '0;
      rd_idx_q   <= '0;
      chk_idx_q  <= '0;
      chk_vld_q  <= 1'b0;
      have_seq_q <= 1'b0;
      prev_seq_q <= '0;
      gap_q      <= '0;
      rs_q       <= '0;
      le_q       <= '0;
      ve_q       <= '0;
      ce_q       <= '0;
      fa_q       <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      fill_q     <= fill_d;
      rd_idx_q   <= rd_idx_d;
      chk_idx_q  <= chk_idx_d;
      chk_vld_q  <= chk_vld_d;
      have_seq_q <= have_seq_d;
      prev_seq_q <= prev_seq_d;
      gap_q      <= gap_d;
      rs_q       <= rs_d;
      le_q       <= le_d;
      ve_q       <= ve_d;
      ce_q       <= ce_d;
      fa_q       <= fa_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    b0_q     <= b0_d;
    len_lo_q <= len_lo_d;
    seq_lo_q <= seq_lo_d;
    seq_q    <= seq_d;
    flen_q   <= flen_d;
    crc_q    <= crc_d;
    out_q    <= out_d;
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.is_status       = out_q.is_status;
  assign out_o.frame_byte      = out_q.frame_byte;
  assign out_o.frame_end       = out_q.frame_end;
  assign out_o.run_last        = out_q.run_last;
  assign out_o.resync_bytes    = out_q.resync_bytes;
  assign out_o.length_errors   = out_q.length_errors;
  assign out_o.version_errors  = out_q.version_errors;
  assign out_o.crc_errors      = out_q.crc_errors;
  assign out_o.frames_accepted = out_q.frames_accepted;
  assign out_o.gap_total       = out_q.gap_total;
  assign out_o.last_sequence   = out_q.last_sequence;

  // window never overfills and the ring head stays in range
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(MAX_FRAME_BYTES))
    else $error("window fill out of range");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q < AW'(MAX_FRAME_BYTES))
    else $error("ring head out of range");

  // a received byte always starts a parse attempt
  a_byte_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.func == FuncByte |=> state_q == S_START)
    else $error("byte beat did not start a scan");

  // frame emission never reads past the frame
  a_emit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT_OUT |-> rd_idx_q < flen_q && flen_q <= fill_q)
    else $error("emit index beyond frame");

  // gap counter only grows
  a_gap_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_d >= gap_q)
    else $error("gap counter decreased");

endmodule

`default_nettype wire

// ===== dv/telemetry_frame_deframer_tb.sv =====
`timescale 1ns / 100ps

module telemetry_frame_deframer_tb;
  import tfd_pkg::*;

  localparam int unsigned WinBytes  = 48;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned LongHold  = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tfd_in_if  in_bus ();
  tfd_out_if out_bus ();

  telemetry_frame_deframer #(.MAX_FRAME_BYTES(WinBytes)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the deframer state
  logic [7:0]  win_q [WinBytes];
  int          win_fill;
  bit          seq_known;
  logic [15:0] seq_prev;
  logic [31:0] gap_sum;

  tfd_item_t   expected_q [$];
  int          mismatch_cnt;
  int          idle_cycles;
  bit          quiet;      // no idling on either side
  bit          hold_req;   // ask the receiver for one long hold-off

  initial begin
    in_bus.valid   = 1'b0;
    in_bus.func    = FuncByte;
    in_bus.rx_byte = 8'h00;
    out_bus.ready  = 1'b0;
    win_fill       = 0;
    seq_known      = 1'b0;
    seq_prev       = '0;
    gap_sum        = '0;
    mismatch_cnt   = 0;
    idle_cycles    = 0;
    quiet          = 1'b0;
    hold_req       = 1'b0;
  end

  // crc-8 poly 0x07, init 0, msb first
  function automatic logic [7:0] crc8_of(input logic [7:0] data [$]);
    logic [7:0] c;
    c = 8'h00;
    foreach (data[i]) begin
      c = c ^ data[i];
      for (int b = 0; b < 8; b++) c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic void drop_front(input int n);
    if (n >= win_fill) begin
      win_fill = 0;
    end else begin
      for (int i = 0; i < win_fill - n; i++) win_q[i] = win_q[i + n];
      win_fill = win_fill - n;
    end
  endfunction

  // works out every beat that one input beat causes and queues it
  task automatic predict_beat(input logic func, input logic [7:0] rx);
    logic [5:0]  rs, le, ve, ce;
    logic [2:0]  fa;
    int          body, flen, emitted;
    logic [15:0] seq, delta;
    logic [31:0] add;
    logic [7:0]  covered [$];
    tfd_item_t   it;
    rs = '0; le = '0; ve = '0; ce = '0; fa = '0; emitted = 0;
    if (func == FuncRestart) begin
      win_fill  = 0;
      seq_known = 1'b0;
    end else begin
      if (win_fill < WinBytes) begin
        win_q[win_fill] = rx;
        win_fill++;
      end
      while (win_fill >= 2) begin
        if (win_q[0] != SyncA || win_q[1] != SyncB) begin
          drop_front(1); rs++;
          continue;
        end
        if (win_fill < 4) break;
        body = int'({win_q[3], win_q[2]});
        flen = 4 + body;
        if (body < int'(MinBody) || flen > WinBytes) begin
          drop_front(1); le++; rs++;
          continue;
        end
        if (win_fill < flen) break;
        if (win_q[4] != GoodVersion) begin
          drop_front(1); ve++; rs++;
          continue;
        end
        covered = {};
        for (int i = 0; i < flen - 1; i++) covered.push_back(win_q[i]);
        if (crc8_of(covered) != win_q[flen - 1]) begin
          drop_front(1); ce++; rs++;
          continue;
        end
        seq = {win_q[6], win_q[5]};
        if (seq_known) begin
          delta = seq - seq_prev;
          if (delta > 16'd1) begin
            add = 32'(delta) - 32'd1;
            // saturate rather than wrap
            gap_sum = (gap_sum > 32'hFFFF_FFFF - add) ? 32'hFFFF_FFFF : gap_sum + add;
          end
        end
        seq_known = 1'b1;
        seq_prev  = seq;
        fa++;
        for (int i = 0; i < flen && emitted < WinBytes; i++) begin
          it            = '0;
          it.frame_byte = win_q[i];
          it.frame_end  = (i == flen - 1);
          expected_q.push_back(it);
          emitted++;
        end
        drop_front(flen);
      end
    end
    it                 = '0;
    it.is_status       = 1'b1;
    it.run_last        = 1'b1;
    it.resync_bytes    = rs;
    it.length_errors   = le;
    it.version_errors  = ve;
    it.crc_errors      = ce;
    it.frames_accepted = fa;
    it.gap_total       = gap_sum;
    it.last_sequence   = seq_prev;
    expected_q.push_back(it);
  endtask

  // one input beat, with an occasional idle burst ahead of it
  task automatic send_beat(input logic func, input logic [7:0] rx);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.func    <= func;
    in_bus.rx_byte <= rx;
    do @(posedge clk_i); while (!in_bus.ready);
    predict_beat(func, rx);
  endtask

  task automatic send_bytes(input logic [7:0] data [$]);
    foreach (data[i]) send_beat(FuncByte, data[i]);
  endtask

  // builds a frame with a legal length and random payload
  task automatic send_frame(input int body, input logic [7:0] ver, input logic [15:0] seq,
                            input bit bad_crc);
    logic [7:0] fr [$];
    logic [7:0] c;
    fr = {SyncA, SyncB, body[7:0], body[15:8], ver, seq[7:0], seq[15:8]};
    for (int i = 0; i < body - 4; i++) fr.push_back(8'($urandom));
    c = crc8_of(fr);
    if (bad_crc) c = c ^ (8'h01 << $urandom_range(0, 7));
    fr.push_back(c);
    send_bytes(fr);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    mismatch_cnt++;
  endtask

  // output checker, field by field against the oldest expectation
  always @(posedge clk_i) begin
    tfd_item_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat, is_status", 32'(out_bus.is_status), 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (out_bus.is_status !== want.is_status)
          report_mismatch("is_status", 32'(out_bus.is_status), 32'(want.is_status));
        if (out_bus.frame_byte !== want.frame_byte)
          report_mismatch("frame_byte", 32'(out_bus.frame_byte), 32'(want.frame_byte));
        if (out_bus.frame_end !== want.frame_end)
          report_mismatch("frame_end", 32'(out_bus.frame_end), 32'(want.frame_end));
        if (out_bus.run_last !== want.run_last)
          report_mismatch("run_last", 32'(out_bus.run_last), 32'(want.run_last));
        if (out_bus.resync_bytes !== want.resync_bytes)
          report_mismatch("resync_bytes", 32'(out_bus.resync_bytes),
                          32'(want.resync_bytes));
        if (out_bus.length_errors !== want.length_errors)
          report_mismatch("length_errors", 32'(out_bus.length_errors),
                          32'(want.length_errors));
        if (out_bus.version_errors !== want.version_errors)
          report_mismatch("version_errors", 32'(out_bus.version_errors),
                          32'(want.version_errors));
        if (out_bus.crc_errors !== want.crc_errors)
          report_mismatch("crc_errors", 32'(out_bus.crc_errors), 32'(want.crc_errors));
        if (out_bus.frames_accepted !== want.frames_accepted)
          report_mismatch("frames_accepted", 32'(out_bus.frames_accepted),
                          32'(want.frames_accepted));
        if (out_bus.gap_total !== want.gap_total)
          report_mismatch("gap_total", out_bus.gap_total, want.gap_total);
        if (out_bus.last_sequence !== want.last_sequence)
          report_mismatch("last_sequence", 32'(out_bus.last_sequence),
                          32'(want.last_sequence));
      end
    end
  end

  // watchdog on cycles where neither side moves a beat
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // status with nothing in flight, shortest and longest good frames, sequence gaps
  task automatic test_good_frames();
    send_beat(FuncRestart, 8'h00);
    send_frame(MinBody, GoodVersion, 16'd5, 1'b0);
    send_frame(MinBody, GoodVersion, 16'd6, 1'b0);      // consecutive, no gap
    send_frame(12, GoodVersion, 16'd10, 1'b0);          // gap of three
    send_frame(MinBody, GoodVersion, 16'd10, 1'b0);     // repeated number adds nothing
    send_frame(WinBytes - 4, GoodVersion, 16'hFFFF, 1'b0);
    send_frame(MinBody, GoodVersion, 16'h0002, 1'b0);   // wraps through zero
  endtask

  // each rejection path, plus garbage ahead of a frame
  task automatic test_bad_frames();
    send_bytes({SyncA, SyncB, 8'd6, 8'd0});              // body too short
    send_bytes({SyncA, SyncB, 8'(WinBytes - 3), 8'd0});  // frame too long
    send_bytes({SyncA, SyncB, 8'hFF, 8'hFF});
    send_frame(MinBody, 8'h00, 16'd20, 1'b0);           // wrong version
    send_frame(MinBody, 8'hFF, 16'd21, 1'b0);
    send_frame(MinBody, GoodVersion, 16'd22, 1'b1);     // corrupt crc
    send_bytes({8'h00, SyncA, SyncA, 8'hFF});
    send_frame(MinBody, GoodVersion, 16'd30, 1'b0);
  endtask

  // restart mid-frame, then the first frame after it counts no gap
  task automatic test_restart();
    send_bytes({SyncA, SyncB, 8'd7, 8'd0, GoodVersion});
    send_beat(FuncRestart, 8'hFF);
    send_frame(MinBody, GoodVersion, 16'd900, 1'b0);
    send_frame(MinBody, GoodVersion, 16'd902, 1'b0);
  endtask

  // receiver holds off while frames keep coming, then the sender waits for the tail
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 3; i++)
      send_frame($urandom_range(7, 20), GoodVersion, seq_prev + 16'd1, 1'b0);
    wait_drained();
  endtask

  // mostly well-formed frames with random content, some broken ones and noise
  task automatic test_random(input int beats);
    int          sent, kind, body;
    logic [15:0] seq;
    sent = 0;
    while (sent < beats) begin
      kind = $urandom_range(0, 19);
      body = ($urandom_range(0, 9) == 0) ? $urandom_range(7, WinBytes - 4)
                                         : $urandom_range(7, 14);
      seq  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : seq_prev + 16'($urandom_range(0, 4));
      if (kind < 13) begin
        send_frame(body, GoodVersion, seq, 1'b0);
        sent += body + 4;
      end else if (kind < 15) begin
        send_frame(body, GoodVersion, seq, 1'b1);
        sent += body + 4;
      end else if (kind == 15) begin
        send_frame(body, 8'($urandom), seq, 1'b0);
        sent += body + 4;
      end else if (kind == 16) begin
        send_beat(FuncRestart, 8'($urandom));
        sent++;
      end else begin
        send_beat(FuncByte, 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_good_frames();
    test_bad_frames();
    test_restart();
    test_backpressure();
    test_random(15);
    // closing stretch with no idling at all
    quiet = 1'b1;
    test_random(15);
    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tfd_pkg.sv
rtl/core/tfd_if.sv
rtl/core/telemetry_frame_deframer.sv
dv/telemetry_frame_deframer_tb.sv
